// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sharpen filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SHARP_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sharpen filter assertion failed");

// Checked on every edge, reset included.
`define SHARP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sharpen filter reset assertion failed");

`endif

// File: rtl/sharp_pkg.sv
// ----------------------------------------------------------------------------
// Sharpen filter package
// Constants, register codes and shared types of the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package sharp_pkg;

  localparam int DEF_MAX_WIDTH    = 2048;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int MAX_HEIGHT       = 4096;
  localparam int MIN_DIM          = 3;
  localparam int CENTER_GAIN      = 5;
  localparam int QUEUE_DEPTH      = 2;

  localparam int SAMPLE_BITS = 8;
  localparam int CFG_W_BITS  = 12;
  localparam int CFG_H_BITS  = 13;
  localparam int CFG_C_BITS  = 3;
  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 32;

  localparam logic [CFG_W_BITS-1:0] RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [CFG_H_BITS-1:0] RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CFG_C_BITS-1:0] RST_CHANNEL_COUNT = 3'd3;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_t;

  // Per-item operation flags handed from the front to the back.
  typedef struct packed {
    logic wr;
    logic emit;
    logic interior;
    logic frame_end;
  } op_flags_t;

endpackage

// File: rtl/sharpen_3x3_filter.sv
// ----------------------------------------------------------------------------
// Sharpen 3x3 filter
// Streams interleaved 8-bit samples in raster order; each result is
// 5*center - left - right - up - down of the same channel, clamped to 0..255,
// and zero on the frame border.
// Input channel: in_valid/in_ready with in_mode (0 sample, 1 drain) and
// in_sample. Output channel: out_valid/out_ready with out_value and
// out_frame_end on the last result of a frame. APB port sets image_width
// (0x0), image_height (0x4) and channel_count (0x8); a write restarts the frame.
// Results trail the input by one image row; drain items flush the last row.
// Throughput is one transfer per cycle on each side while in_ready and
// out_ready stay high. A sample reaches the output register through the
// two-entry queue, the line store read stage and the kernel stage.
// Reset clears the frame position and out_valid; the line store holds no
// reset value. Input is held off after reset and after any register write
// while the frame geometry is recomputed.
// When the receiver stalls, the output register and back pipeline freeze and
// the queue absorbs up to two items before in_ready drops.
// ----------------------------------------------------------------------------
module sharpen_3x3_filter #(
  parameter int MAX_WIDTH    = sharp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = sharp_pkg::DEF_MAX_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic [sharp_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sharp_pkg::SAMPLE_BITS-1:0] out_value,
  output logic                              out_frame_end,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sharp_pkg::PADDR_BITS-1:0]  paddr,
  input  logic [sharp_pkg::PDATA_BITS-1:0]  pwdata,
  output logic [sharp_pkg::PDATA_BITS-1:0]  prdata,
  output logic                              pready
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HM = $clog2(sharp_pkg::MAX_HEIGHT);
  localparam int CW = $clog2(MAX_CHANNELS+1);
  localparam int LW = $clog2(MAX_WIDTH*MAX_CHANNELS+1);
  localparam int AW = $clog2(2*MAX_WIDTH*MAX_CHANNELS);
  localparam int RW = AW + 1;
  localparam int TW = $clog2(MAX_WIDTH*MAX_CHANNELS*sharp_pkg::MAX_HEIGHT+1);
  localparam int FW = $bits(sharp_pkg::op_flags_t);
  localparam int QW = FW + 2*AW + sharp_pkg::SAMPLE_BITS;

  logic          restart;
  logic          geo_ready;
  logic [WW-1:0] w_m1;
  logic [HM-1:0] h_m1;
  logic [CW-1:0] ch;
  logic [LW-1:0] row_len;
  logic [RW-1:0] ring_len;
  logic [RW-1:0] mid_off;
  logic [TW-1:0] total;

  logic                 f_push, f_ready;
  sharp_pkg::op_flags_t f_flags;
  logic [AW-1:0]        f_waddr, f_maddr;
  logic [sharp_pkg::SAMPLE_BITS-1:0] f_sample;

  logic                 b_valid, b_pop;
  logic [QW-1:0]        b_data;
  sharp_pkg::op_flags_t b_flags;
  logic [AW-1:0]        b_waddr, b_maddr;
  logic [sharp_pkg::SAMPLE_BITS-1:0] b_sample;

  sharp_regs #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .restart   (restart),
    .geo_ready (geo_ready),
    .w_m1      (w_m1),
    .h_m1      (h_m1),
    .ch        (ch),
    .row_len   (row_len),
    .ring_len  (ring_len),
    .mid_off   (mid_off),
    .total     (total)
  );

  sharp_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_sample (in_sample),
    .restart   (restart),
    .geo_ready (geo_ready),
    .w_m1      (w_m1),
    .h_m1      (h_m1),
    .ch        (ch),
    .row_len   (row_len),
    .ring_len  (ring_len),
    .mid_off   (mid_off),
    .total     (total),
    .q_ready   (f_ready),
    .q_push    (f_push),
    .q_flags   (f_flags),
    .q_waddr   (f_waddr),
    .q_maddr   (f_maddr),
    .q_sample  (f_sample)
  );

  sharp_queue #(
    .WIDTH (QW),
    .DEPTH (sharp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_data  ({f_flags, f_waddr, f_maddr, f_sample}),
    .push_ready (f_ready),
    .pop        (b_pop),
    .pop_data   (b_data),
    .pop_valid  (b_valid)
  );

  assign {b_flags, b_waddr, b_maddr, b_sample} = b_data;

  sharp_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (b_valid),
    .q_pop         (b_pop),
    .q_flags       (b_flags),
    .q_waddr       (b_waddr),
    .q_maddr       (b_maddr),
    .q_sample      (b_sample),
    .ch            (ch),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_frame_end (out_frame_end)
  );

endmodule

// File: rtl/sharp_regs.sv
// ----------------------------------------------------------------------------
// Sharpen filter registers
// APB register file and registered frame geometry derived from it.
// ----------------------------------------------------------------------------
module sharp_regs #(
  parameter int MAX_WIDTH    = sharp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = sharp_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sharp_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [sharp_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [sharp_pkg::PDATA_BITS-1:0]    prdata,
  output logic                                pready,
  output logic                                restart,
  output logic                                geo_ready,
  output logic [$clog2(MAX_WIDTH+1)-1:0]      w_m1,
  output logic [$clog2(sharp_pkg::MAX_HEIGHT)-1:0] h_m1,
  output logic [$clog2(MAX_CHANNELS+1)-1:0]   ch,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS+1)-1:0] row_len,
  output logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS):0]   ring_len,
  output logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS):0]   mid_off,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS*sharp_pkg::MAX_HEIGHT+1)-1:0] total
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HM = $clog2(sharp_pkg::MAX_HEIGHT);
  localparam int HW = $clog2(sharp_pkg::MAX_HEIGHT+1);
  localparam int CW = $clog2(MAX_CHANNELS+1);
  localparam int LW = $clog2(MAX_WIDTH*MAX_CHANNELS+1);
  localparam int RW = $clog2(2*MAX_WIDTH*MAX_CHANNELS) + 1;
  localparam int TW = $clog2(MAX_WIDTH*MAX_CHANNELS*sharp_pkg::MAX_HEIGHT+1);

  logic [sharp_pkg::CFG_W_BITS-1:0] image_width_r;
  logic [sharp_pkg::CFG_H_BITS-1:0] image_height_r;
  logic [sharp_pkg::CFG_C_BITS-1:0] channel_count_r;
  logic [1:0]                       settle_r;

  logic        wr_en;
  logic        known_reg;
  int unsigned w_ext, h_ext, c_ext;
  logic [WW-1:0] w_cl;
  logic [HW-1:0] h_cl;
  logic [CW-1:0] c_cl;

  logic [WW-1:0] w_m1_r;
  logic [HM-1:0] h_m1_r;
  logic [HW-1:0] h_r;
  logic [CW-1:0] ch_r;
  logic [LW-1:0] row_len_r;
  logic [RW-1:0] ring_len_r;
  logic [RW-1:0] mid_off_r;
  logic [TW-1:0] total_r;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    known_reg = 1'b0;
    case (sharp_pkg::reg_idx_t'(paddr[3:2]))
      sharp_pkg::REG_IMAGE_WIDTH: begin
        known_reg = 1'b1;
        prdata    = sharp_pkg::PDATA_BITS'(image_width_r);
      end
      sharp_pkg::REG_IMAGE_HEIGHT: begin
        known_reg = 1'b1;
        prdata    = sharp_pkg::PDATA_BITS'(image_height_r);
      end
      sharp_pkg::REG_CHANNEL_COUNT: begin
        known_reg = 1'b1;
        prdata    = sharp_pkg::PDATA_BITS'(channel_count_r);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign restart = wr_en && known_reg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= sharp_pkg::RST_IMAGE_WIDTH;
      image_height_r  <= sharp_pkg::RST_IMAGE_HEIGHT;
      channel_count_r <= sharp_pkg::RST_CHANNEL_COUNT;
      settle_r        <= 2'd3;
    end else begin
      if (wr_en) begin
        settle_r <= 2'd3;
        case (sharp_pkg::reg_idx_t'(paddr[3:2]))
          sharp_pkg::REG_IMAGE_WIDTH:   image_width_r   <= pwdata[sharp_pkg::CFG_W_BITS-1:0];
          sharp_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= pwdata[sharp_pkg::CFG_H_BITS-1:0];
          sharp_pkg::REG_CHANNEL_COUNT: channel_count_r <= pwdata[sharp_pkg::CFG_C_BITS-1:0];
          default: ;
        endcase
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  assign geo_ready = (settle_r == 2'd0);

  // clamp to the supported ranges
  always_comb begin
    w_ext = 32'(image_width_r);
    h_ext = 32'(image_height_r);
    c_ext = 32'(channel_count_r);
    if (w_ext < sharp_pkg::MIN_DIM) w_ext = sharp_pkg::MIN_DIM;
    if (w_ext > MAX_WIDTH)          w_ext = MAX_WIDTH;
    if (h_ext < sharp_pkg::MIN_DIM) h_ext = sharp_pkg::MIN_DIM;
    if (h_ext > sharp_pkg::MAX_HEIGHT) h_ext = sharp_pkg::MAX_HEIGHT;
    if (c_ext < 1)                  c_ext = 1;
    if (c_ext > MAX_CHANNELS)       c_ext = MAX_CHANNELS;
    w_cl = WW'(w_ext);
    h_cl = HW'(h_ext);
    c_cl = CW'(c_ext);
  end

  always_ff @(posedge clk) begin
    w_m1_r     <= w_cl - WW'(1);
    h_m1_r     <= HM'(h_cl - HW'(1));
    h_r        <= h_cl;
    ch_r       <= c_cl;
    row_len_r  <= LW'(w_cl) * LW'(c_cl);
    ring_len_r <= RW'(row_len_r) + RW'(row_len_r);
    mid_off_r  <= RW'(row_len_r) + RW'(ch_r);
    total_r    <= TW'(row_len_r) * TW'(h_r);
  end

  assign w_m1     = w_m1_r;
  assign h_m1     = h_m1_r;
  assign ch       = ch_r;
  assign row_len  = row_len_r;
  assign ring_len = ring_len_r;
  assign mid_off  = mid_off_r;
  assign total    = total_r;

endmodule

// File: rtl/sharp_front.sv
// ----------------------------------------------------------------------------
// Sharpen filter front
// Accepts items, tracks frame position and classifies each transfer.
// ----------------------------------------------------------------------------
module sharp_front #(
  parameter int MAX_WIDTH    = sharp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = sharp_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [sharp_pkg::SAMPLE_BITS-1:0]   in_sample,
  input  logic                                restart,
  input  logic                                geo_ready,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      w_m1,
  input  logic [$clog2(sharp_pkg::MAX_HEIGHT)-1:0] h_m1,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]   ch,
  input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS+1)-1:0] row_len,
  input  logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS):0]   ring_len,
  input  logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS):0]   mid_off,
  input  logic [$clog2(MAX_WIDTH*MAX_CHANNELS*sharp_pkg::MAX_HEIGHT+1)-1:0] total,
  input  logic                                q_ready,
  output logic                                q_push,
  output sharp_pkg::op_flags_t                q_flags,
  output logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS)-1:0] q_waddr,
  output logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS)-1:0] q_maddr,
  output logic [sharp_pkg::SAMPLE_BITS-1:0]   q_sample
);

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HM = $clog2(sharp_pkg::MAX_HEIGHT);
  localparam int CW = $clog2(MAX_CHANNELS+1);
  localparam int AW = $clog2(2*MAX_WIDTH*MAX_CHANNELS);
  localparam int RW = AW + 1;
  localparam int TW = $clog2(MAX_WIDTH*MAX_CHANNELS*sharp_pkg::MAX_HEIGHT+1);

  logic [TW-1:0] in_cnt_r,  in_cnt_nxt;
  logic [TW-1:0] out_cnt_r, out_cnt_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic [CW-1:0] chn_r,     chn_nxt;
  logic [WW-1:0] col_r,     col_nxt;
  logic [HM-1:0] row_r,     row_nxt;

  logic          take;
  logic          is_smp;
  logic          emit;
  logic          interior;
  logic          frame_end;
  logic [TW-1:0] out_inc;
  logic [RW-1:0] wr_inc;
  logic [RW:0]   mid_sum;
  logic [RW:0]   ring_ext;

  assign in_ready = q_ready && geo_ready;
  assign take     = in_valid && in_ready;

  assign is_smp   = !in_mode && (in_cnt_r < total);
  assign emit     = is_smp ? (in_cnt_r >= TW'(row_len))
                           : ((in_cnt_r >= total) && (out_cnt_r < total));
  assign interior = is_smp && (row_r != '0) && (row_r < h_m1) &&
                    (col_r != '0) && (col_r < w_m1);
  assign out_inc  = out_cnt_r + TW'(1);
  assign frame_end = (out_inc == total);

  // ring slot of the sample one row behind plus one pixel
  assign ring_ext = (RW+1)'(ring_len);
  assign mid_sum  = (RW+1)'(wr_addr_r) + (RW+1)'(mid_off);
  assign q_maddr  = AW'((mid_sum >= ring_ext) ? (mid_sum - ring_ext) : mid_sum);

  assign wr_inc   = RW'(wr_addr_r) + RW'(1);

  assign q_push   = take && (is_smp || emit);
  assign q_waddr  = wr_addr_r;
  assign q_sample = in_sample;
  assign q_flags  = '{wr: is_smp, emit: emit, interior: interior, frame_end: frame_end};

  always_comb begin
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    wr_addr_nxt = wr_addr_r;
    chn_nxt     = chn_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (take) begin
      if (is_smp) begin
        in_cnt_nxt  = in_cnt_r + TW'(1);
        wr_addr_nxt = (wr_inc == ring_len) ? '0 : AW'(wr_inc);
      end
      if (emit) begin
        out_cnt_nxt = out_inc;
        if (chn_r == ch - CW'(1)) begin
          chn_nxt = '0;
          if (col_r == w_m1) begin
            col_nxt = '0;
            row_nxt = row_r + HM'(1);
          end else begin
            col_nxt = col_r + WW'(1);
          end
        end else begin
          chn_nxt = chn_r + CW'(1);
        end
        if (frame_end) begin
          in_cnt_nxt  = '0;
          out_cnt_nxt = '0;
          wr_addr_nxt = '0;
          chn_nxt     = '0;
          col_nxt     = '0;
          row_nxt     = '0;
        end
      end
    end
    if (restart) begin
      in_cnt_nxt  = '0;
      out_cnt_nxt = '0;
      wr_addr_nxt = '0;
      chn_nxt     = '0;
      col_nxt     = '0;
      row_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r  <= '0;
      out_cnt_r <= '0;
      wr_addr_r <= '0;
      chn_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
      wr_addr_r <= wr_addr_nxt;
      chn_r     <= chn_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
    end
  end

endmodule

// File: rtl/sharp_queue.sv
// ----------------------------------------------------------------------------
// Sharpen filter queue
// Small register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module sharp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sharp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             pop_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [NW-1:0]    count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != NW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// File: rtl/sharp_back.sv
// ----------------------------------------------------------------------------
// Sharpen filter back
// Line store, neighbor window, kernel arithmetic and output register.
// ----------------------------------------------------------------------------
module sharp_back #(
  parameter int MAX_WIDTH    = sharp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = sharp_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  sharp_pkg::op_flags_t                q_flags,
  input  logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS)-1:0] q_waddr,
  input  logic [$clog2(2*MAX_WIDTH*MAX_CHANNELS)-1:0] q_maddr,
  input  logic [sharp_pkg::SAMPLE_BITS-1:0]   q_sample,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]   ch,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sharp_pkg::SAMPLE_BITS-1:0]   out_value,
  output logic                                out_frame_end
);

  localparam int DEPTH = 2 * MAX_WIDTH * MAX_CHANNELS;
  localparam int CW    = $clog2(MAX_CHANNELS+1);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SB    = sharp_pkg::SAMPLE_BITS;

  logic [SB-1:0] mem [DEPTH];

  logic                 en;
  logic [SB-1:0]        above_r, mid_r;
  logic                 s1_valid_r;
  sharp_pkg::op_flags_t s1_flags_r;
  logic [SB-1:0]        s1_sample_r;

  logic [SB-1:0] cen_r [MAX_CHANNELS];
  logic [SB-1:0] lft_r [MAX_CHANNELS];
  logic [SB-1:0] cen_nxt [MAX_CHANNELS];
  logic [SB-1:0] lft_nxt [MAX_CHANNELS];
  logic [CHW-1:0] ch_last;

  logic [SB+2:0] pos;
  logic [SB+1:0] neg;
  logic [SB+2:0] diff;
  logic [SB-1:0] sharp;

  logic          out_valid_r;
  logic [SB-1:0] out_value_r;
  logic          out_frame_end_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      above_r <= mem[q_waddr];
      mid_r   <= mem[q_maddr];
      if (q_flags.wr) begin
        mem[q_waddr] <= q_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flags_r  <= q_flags;
      s1_sample_r <= q_sample;
    end
  end

  // center and left come from the same-row stream delayed by ch and 2*ch
  assign ch_last = CHW'(ch - CW'(1));

  always_comb begin
    cen_nxt = cen_r;
    lft_nxt = lft_r;
    for (int j = 0; j < MAX_CHANNELS - 1; j++) begin
      if (j < int'(ch_last)) begin
        cen_nxt[j] = cen_r[j+1];
        lft_nxt[j] = lft_r[j+1];
      end
    end
    cen_nxt[ch_last] = mid_r;
    lft_nxt[ch_last] = cen_r[0];
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid_r && s1_flags_r.wr) begin
      cen_r <= cen_nxt;
      lft_r <= lft_nxt;
    end
  end

  always_comb begin
    pos  = (SB+3)'(cen_r[0]) * (SB+3)'(sharp_pkg::CENTER_GAIN);
    neg  = (SB+2)'(lft_r[0]) + (SB+2)'(mid_r) + (SB+2)'(above_r) + (SB+2)'(s1_sample_r);
    diff = pos - (SB+3)'(neg);
    if (pos <= (SB+3)'(neg)) begin
      sharp = '0;
    end else if (diff > (SB+3)'(255)) begin
      sharp = '1;
    end else begin
      sharp = SB'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_pop;
      out_valid_r <= s1_valid_r && s1_flags_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r     <= s1_flags_r.interior ? sharp : '0;
      out_frame_end_r <= s1_flags_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// File: rtl/sharp_checker.sv
// ----------------------------------------------------------------------------
// Sharpen filter checker
// Port-level assertions for the sharpen filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sharp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [sharp_pkg::SAMPLE_BITS-1:0] out_value,
  input logic                              out_frame_end,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready
);

  `SHARP_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)

  `SHARP_ASSERT(a_reset_holds_input, clk, rst_n, $rose(rst_n) |-> !in_ready)

  `SHARP_ASSERT(a_cfg_holds_input, clk, rst_n, (psel && penable && pwrite && pready) |=> !in_ready)

  `SHARP_ASSERT(a_out_stall_holds, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_frame_end)))

endmodule

bind sharpen_3x3_filter sharp_checker u_sharp_checker (.*);
